@@ sv/packet_header_rewrite_assert.svh @@
// ----------------------------------------------------------------------------
// packet_header_rewrite assertion macros
// Shared concurrent assertion forms for the header rewrite checkers.
// ----------------------------------------------------------------------------
`ifndef PACKET_HEADER_REWRITE_ASSERT_SVH
`define PACKET_HEADER_REWRITE_ASSERT_SVH

// Checked out of reset only
`define PHR_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Checked at every edge, reset included
`define PHR_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ sv/phr_pkg.sv @@
// ----------------------------------------------------------------------------
// phr_pkg
// Shared constants and controller/datapath interface types for the
// Ethernet/IPv4 header rewrite block.
// ----------------------------------------------------------------------------
package phr_pkg;

  // Default header buffer depth in 8-byte words (legal range 10..16)
  localparam int unsigned HDR_WORDS_DEF = 10;

  // Word index into the header buffer, enough for any depth in range
  localparam int unsigned IDX_W  = 4;
  // Number of held words, can reach the full depth
  localparam int unsigned HELD_W = 5;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 48;

  localparam logic [CFG_IDX_W-1:0] CFG_MODE       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OLD_IP     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NEW_IP     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_OLD_MAC    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_NEW_MAC    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_MATCH_PORT = 3'd5;

  // Mode register bit positions
  localparam int unsigned M_SRC_IP  = 0;
  localparam int unsigned M_DST_IP  = 1;
  localparam int unsigned M_SRC_MAC = 2;
  localparam int unsigned M_DST_MAC = 3;
  localparam int unsigned M_SPORT   = 4;
  localparam int unsigned M_DPORT   = 5;
  localparam int unsigned MODE_W    = 6;

  // Controller to datapath commands
  typedef struct packed {
    logic              capt;        // store the accepted word at widx
    logic [IDX_W-1:0]  widx;
    logic              pass_load;   // load output register from the input
    logic              ip_step;     // IP and MAC match rewrites
    logic              sum_step;    // checksum partial sum
    logic              fold_step;   // checksum fold and write
    logic              port_step;   // L4 port test and source MAC set
    logic              flush_load;  // load output from buffer head and shift
    logic              flush_last;  // last flag for the flushed word
    logic [HELD_W-1:0] held;        // words held for the current frame
  } phr_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic out_free;                 // output register can take a word
  } phr_sts_t;

endpackage

@@ sv/phr_dp.sv @@
// ----------------------------------------------------------------------------
// phr_dp
// Datapath: configuration registers, header byte buffer, rewrite logic,
// checksum sum/fold and the output register.
// ----------------------------------------------------------------------------
module phr_dp import phr_pkg::*; #(
  parameter int unsigned HDR_WORDS = HDR_WORDS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration writes
  input  logic                  cfg_valid_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  // input payload
  input  logic [63:0]           word_data_i,
  input  logic [3:0]            byte_count_i,
  input  logic                  end_of_frame_i,
  // control
  input  phr_cmd_t              cmd_i,
  output phr_sts_t              sts_o,
  // output channel
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [63:0]           out_data_o,
  output logic [3:0]            out_count_o,
  output logic                  out_last_o
);

  localparam int unsigned NB = HDR_WORDS * 8;

  // Configuration registers
  logic [MODE_W-1:0] mode_q;
  logic [31:0]       old_ip_q;
  logic [31:0]       new_ip_q;
  logic [47:0]       old_mac_q;
  logic [47:0]       new_mac_q;
  logic [15:0]       match_port_q;

  // Header buffer as bytes, frame byte p at index p
  logic [7:0]  fb_q  [NB];
  logic [7:0]  fb_d  [NB];
  logic [3:0]  cnt_q [HDR_WORDS];
  logic [3:0]  cnt_d [HDR_WORDS];
  logic [19:0] sum_q;
  logic [19:0] sum_d;

  logic [NB-1:0] pres;
  logic [15:0]   hw [10];
  logic [16:0]   ps [5];
  logic [16:0]   fold1;
  logic [15:0]   fold2;
  logic [3:0]    ihl;
  logic [31:0]   pv;
  logic [3:0]    pp;
  logic          sport_hit;
  logic          dport_hit;
  logic [63:0]   head_word;

  logic        out_valid_q;
  logic [63:0] out_data_q;
  logic [3:0]  out_count_q;
  logic        out_last_q;

  // Configuration register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= '0;
      old_ip_q     <= '0;
      new_ip_q     <= '0;
      old_mac_q    <= '0;
      new_mac_q    <= '0;
      match_port_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_MODE:       mode_q       <= cfg_data_i[MODE_W-1:0];
        CFG_OLD_IP:     old_ip_q     <= cfg_data_i[31:0];
        CFG_NEW_IP:     new_ip_q     <= cfg_data_i[31:0];
        CFG_OLD_MAC:    old_mac_q    <= cfg_data_i[47:0];
        CFG_NEW_MAC:    new_mac_q    <= cfg_data_i[47:0];
        CFG_MATCH_PORT: match_port_q <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // Byte presence: word held and byte below its count (counts above 8 act as 8)
  always_comb begin
    for (int w = 0; w < HDR_WORDS; w++) begin
      for (int k = 0; k < 8; k++) begin
        pres[w*8+k] = (HELD_W'(w) < cmd_i.held) &&
                      (cnt_q[w][3] || (3'(k) < cnt_q[w][2:0]));
      end
    end
  end

  // Checksum halfwords over bytes 14..33, the checksum field reads as zero
  always_comb begin
    for (int i = 0; i < 10; i++) begin
      hw[i] = (i == 5) ? 16'h0000 : {fb_q[14+2*i], fb_q[15+2*i]};
    end
    for (int j = 0; j < 5; j++) begin
      ps[j] = 17'(hw[2*j]) + 17'(hw[2*j+1]);
    end
  end

  // End-around carry fold of the registered sum
  assign fold1 = 17'(sum_q[19:16]) + 17'(sum_q[15:0]);
  assign fold2 = 16'(fold1[16]) + fold1[15:0];

  // L4 port field at byte 14 + 4*IHL
  assign ihl = fb_q[14][3:0];
  always_comb begin
    pv = '0;
    pp = '0;
    for (int j = 0; j < 16; j++) begin
      if (ihl == 4'(j)) begin
        pv = {fb_q[14+4*j], fb_q[15+4*j], fb_q[16+4*j], fb_q[17+4*j]};
        pp = pres[14+4*j +: 4];
      end
    end
  end
  assign sport_hit = mode_q[M_SPORT] && pp[0] && pp[1] && (pv[31:16] == match_port_q);
  assign dport_hit = mode_q[M_DPORT] && pp[2] && pp[3] && (pv[15:0] == match_port_q);

  // Buffer next state
  always_comb begin
    fb_d  = fb_q;
    cnt_d = cnt_q;
    sum_d = sum_q;

    // capture
    if (cmd_i.capt) begin
      for (int w = 0; w < HDR_WORDS; w++) begin
        if (cmd_i.widx == IDX_W'(w)) begin
          for (int k = 0; k < 8; k++) begin
            fb_d[w*8+k] = word_data_i[63-8*k -: 8];
          end
          cnt_d[w] = byte_count_i;
        end
      end
    end

    // address matches
    if (cmd_i.ip_step) begin
      if (mode_q[M_SRC_IP] && (&pres[26 +: 4]) &&
          ({fb_q[26], fb_q[27], fb_q[28], fb_q[29]} == old_ip_q)) begin
        for (int k = 0; k < 4; k++) fb_d[26+k] = new_ip_q[31-8*k -: 8];
      end
      if (mode_q[M_DST_IP] && (&pres[30 +: 4]) &&
          ({fb_q[30], fb_q[31], fb_q[32], fb_q[33]} == old_ip_q)) begin
        for (int k = 0; k < 4; k++) fb_d[30+k] = new_ip_q[31-8*k -: 8];
      end
      if (mode_q[M_SRC_MAC] && (&pres[6 +: 6]) &&
          ({fb_q[6], fb_q[7], fb_q[8], fb_q[9], fb_q[10], fb_q[11]} == old_mac_q)) begin
        for (int k = 0; k < 6; k++) fb_d[6+k] = new_mac_q[47-8*k -: 8];
      end
      if (mode_q[M_DST_MAC] && (&pres[0 +: 6]) &&
          ({fb_q[0], fb_q[1], fb_q[2], fb_q[3], fb_q[4], fb_q[5]} == old_mac_q)) begin
        for (int k = 0; k < 6; k++) fb_d[k] = new_mac_q[47-8*k -: 8];
      end
    end

    // checksum sum
    if (cmd_i.sum_step) begin
      sum_d = 20'(ps[0]) + 20'(ps[1]) + 20'(ps[2]) + 20'(ps[3]) + 20'(ps[4]);
    end

    // checksum write, when an IP rewrite is enabled and bytes 14..33 are held
    if (cmd_i.fold_step) begin
      if ((mode_q[M_SRC_IP] || mode_q[M_DST_IP]) && (&pres[14 +: 20])) begin
        fb_d[24] = ~fold2[15:8];
        fb_d[25] = ~fold2[7:0];
      end
    end

    // port-selected source MAC
    if (cmd_i.port_step) begin
      if (pres[14] && (sport_hit || dport_hit) && (&pres[6 +: 6])) begin
        for (int k = 0; k < 6; k++) fb_d[6+k] = new_mac_q[47-8*k -: 8];
      end
    end

    // flush: shift the buffer down one word
    if (cmd_i.flush_load) begin
      for (int i = 0; i < NB - 8; i++) fb_d[i] = fb_q[i+8];
      for (int w = 0; w < HDR_WORDS - 1; w++) cnt_d[w] = cnt_q[w+1];
    end
  end

  always_ff @(posedge clk_i) begin
    fb_q  <= fb_d;
    cnt_q <= cnt_d;
    sum_q <= sum_d;
  end

  // Buffer head word
  always_comb begin
    for (int k = 0; k < 8; k++) head_word[63-8*k -: 8] = fb_q[k];
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.pass_load || cmd_i.flush_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.pass_load) begin
      out_data_q  <= word_data_i;
      out_count_q <= byte_count_i;
      out_last_q  <= end_of_frame_i;
    end else if (cmd_i.flush_load) begin
      out_data_q  <= head_word;
      out_count_q <= cnt_q[0];
      out_last_q  <= cmd_i.flush_last;
    end
  end

  assign sts_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o    = out_valid_q;
  assign out_data_o     = out_data_q;
  assign out_count_o    = out_count_q;
  assign out_last_o     = out_last_q;

endmodule

@@ sv/phr_ctrl.sv @@
// ----------------------------------------------------------------------------
// phr_ctrl
// Controller: frame capture, rewrite sequence, header flush and
// pass-through of the frame tail.
// ----------------------------------------------------------------------------
module phr_ctrl import phr_pkg::*; #(
  parameter int unsigned HDR_WORDS = HDR_WORDS_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  logic     end_of_frame_i,
  output logic     in_ready_o,
  input  phr_sts_t sts_i,
  output phr_cmd_t cmd_o
);

  typedef enum logic [2:0] {
    ST_CAPT,
    ST_PASS,
    ST_IP,
    ST_SUM,
    ST_FOLD,
    ST_PORT,
    ST_FLUSH
  } state_e;

  state_e            state_q;
  logic [IDX_W-1:0]  widx_q;
  logic [IDX_W-1:0]  fcnt_q;
  logic [HELD_W-1:0] held_q;
  logic              eof_q;

  logic in_acc;
  logic flush_end;

  assign in_ready_o = (state_q == ST_CAPT) || ((state_q == ST_PASS) && sts_i.out_free);
  assign in_acc     = in_valid_i && in_ready_o;
  assign flush_end  = ((HELD_W'(fcnt_q) + HELD_W'(1)) == held_q);

  // Commands
  always_comb begin
    cmd_o            = '0;
    cmd_o.capt       = (state_q == ST_CAPT) && in_acc;
    cmd_o.widx       = widx_q;
    cmd_o.pass_load  = (state_q == ST_PASS) && in_acc;
    cmd_o.ip_step    = (state_q == ST_IP);
    cmd_o.sum_step   = (state_q == ST_SUM);
    cmd_o.fold_step  = (state_q == ST_FOLD);
    cmd_o.port_step  = (state_q == ST_PORT);
    cmd_o.flush_load = (state_q == ST_FLUSH) && sts_i.out_free;
    cmd_o.flush_last = flush_end && eof_q;
    cmd_o.held       = held_q;
  end

  // State and counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CAPT;
      widx_q  <= '0;
      fcnt_q  <= '0;
      held_q  <= '0;
      eof_q   <= 1'b0;
    end else begin
      case (state_q)
        ST_CAPT: begin
          // hold header words until frame end or buffer full
          if (in_acc) begin
            if (end_of_frame_i || (widx_q == IDX_W'(HDR_WORDS - 1))) begin
              held_q  <= HELD_W'(widx_q) + HELD_W'(1);
              eof_q   <= end_of_frame_i;
              widx_q  <= '0;
              state_q <= ST_IP;
            end else begin
              widx_q <= widx_q + IDX_W'(1);
            end
          end
        end
        ST_PASS: begin
          if (in_acc && end_of_frame_i) state_q <= ST_CAPT;
        end
        ST_IP:   state_q <= ST_SUM;
        ST_SUM:  state_q <= ST_FOLD;
        ST_FOLD: state_q <= ST_PORT;
        ST_PORT: begin
          fcnt_q  <= '0;
          state_q <= ST_FLUSH;
        end
        ST_FLUSH: begin
          // one held word per free output slot
          if (sts_i.out_free) begin
            if (flush_end) begin
              state_q <= eof_q ? ST_CAPT : ST_PASS;
            end else begin
              fcnt_q <= fcnt_q + IDX_W'(1);
            end
          end
        end
        default: state_q <= ST_CAPT;
      endcase
    end
  end

endmodule

@@ sv/packet_header_rewrite.sv @@
// ----------------------------------------------------------------------------
// packet_header_rewrite
// Ethernet/IPv4 header rewrite with IPv4 checksum update, top level.
// ----------------------------------------------------------------------------
// Frames arrive as 8-byte words. The first HDR_WORDS words are held, one per
// cycle, until the last word of the frame or a full buffer; the block then
// runs the rewrite steps in order (address matches, checksum sum, checksum
// fold, L4 port test) and sends the held words out one per cycle as the output
// register frees, with input stalled meanwhile. The remaining words of a longer
// frame pass through the output register at one word per cycle as it frees.
// Configuration writes are always accepted and apply to later rewrite steps.
module packet_header_rewrite import phr_pkg::*; #(
  parameter int unsigned HDR_WORDS = HDR_WORDS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration channel
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  // input channel
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [63:0]           word_data_i,
  input  logic [3:0]            byte_count_i,
  input  logic                  end_of_frame_i,
  // output channel
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [63:0]           out_data_o,
  output logic [3:0]            out_count_o,
  output logic                  out_last_o
);

  phr_cmd_t cmd;
  phr_sts_t sts;

  assign cfg_ready_o = 1'b1;

  phr_ctrl #(
    .HDR_WORDS (HDR_WORDS)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .end_of_frame_i (end_of_frame_i),
    .in_ready_o     (in_ready_o),
    .sts_i          (sts),
    .cmd_o          (cmd)
  );

  phr_dp #(
    .HDR_WORDS (HDR_WORDS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .word_data_i    (word_data_i),
    .byte_count_i   (byte_count_i),
    .end_of_frame_i (end_of_frame_i),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_data_o     (out_data_o),
    .out_count_o    (out_count_o),
    .out_last_o     (out_last_o)
  );

endmodule

@@ sv/phr_chk.sv @@
// ----------------------------------------------------------------------------
// phr_chk
// Port-level assertions for packet_header_rewrite, bound to the top level.
// ----------------------------------------------------------------------------
`include "packet_header_rewrite_assert.svh"

module phr_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [63:0] out_data_o,
  input logic [3:0]  out_count_o,
  input logic        out_last_o
);

  // stalled output request stays up
  `PHR_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i |=> out_valid_o, "output request dropped while stalled")

  // stalled output payload holds
  `PHR_ASSERT(a_out_stable, clk_i, rst_ni, out_valid_o && !out_ready_i |=> $stable(out_data_o) && $stable(out_count_o) && $stable(out_last_o), "output payload changed while stalled")

  // taking an input word never disturbs a waiting result
  `PHR_ASSERT(a_in_vs_out, clk_i, rst_ni, in_valid_i && in_ready_o && out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o), "waiting result overwritten by input")

  // reset seen at an edge clears the output request by the next edge
  `PHR_ASSERT_ALWAYS(a_rst_out, clk_i, !rst_ni |=> !out_valid_o, "output request during reset")

endmodule

bind packet_header_rewrite phr_chk u_phr_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o),
  .out_count_o (out_count_o),
  .out_last_o  (out_last_o)
);
